// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the deque core files
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must never hold outside reset
`define ASSERT_NEVER(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// ===== rtl/core/deq_pkg.sv =====
// types, constants and command codes for the deque core
// used by deq_cell, deq_ctrl and double_ended_queue_core
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int CMD_W = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0] count_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_t;

    // move requests common to every cell of the row
    typedef struct packed {
        logic shift_r;   // take the word of the cell toward the front
        logic shift_l;   // take the word of the cell toward the back
    } cell_ctrl_t;

    // outcome of the accepted command
    typedef struct packed {
        logic is_empty;  // queue empty after the command
        logic overflow;  // push dropped on full queue
        logic pop_hit;   // pop that returns a stored word
        logic pop_miss;  // pop on empty queue
    } deq_status_t;

endpackage

// ===== rtl/core/deq_cell.sv =====
// one storage cell of the deque row: holds a word, loads it from the
// input or from either neighbor; uses deq_pkg
module deq_cell (
    input  logic               clk,
    input  deq_pkg::cell_ctrl_t ctrl,
    input  logic               wr_en,
    input  deq_pkg::word_t     data_in,
    input  deq_pkg::word_t     left_data,
    input  deq_pkg::word_t     right_data,
    output deq_pkg::word_t     data
);
    import deq_pkg::*;

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        priority if (wr_en)
            data_next = data_in;
        else if (ctrl.shift_r)
            data_next = left_data;
        else if (ctrl.shift_l)
            data_next = right_data;
        else
            data_next = data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// fill count and command decode for the deque row; drives the cell moves,
// the write and read selects and the result flags; uses deq_pkg and the macros
`include "assert_macros.svh"
module deq_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [deq_pkg::CMD_W-1:0] cmd,
    output deq_pkg::cell_ctrl_t      ctrl,
    output logic [deq_pkg::DEPTH-1:0] wr_sel,
    output logic [deq_pkg::DEPTH-1:0] rd_sel,
    output deq_pkg::deq_status_t     status
);
    import deq_pkg::*;

    count_t count_reg;
    count_t count_next;
    logic   full;
    logic   empty;
    logic   push_back;
    logic   push_front;
    logic   pop_back;
    logic   pop_front;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        push_back  = 1'b0;
        push_front = 1'b0;
        pop_back   = 1'b0;
        pop_front  = 1'b0;
        unique case (cmd)
            CMD_PUSH_BACK:  push_back  = 1'b1;
            CMD_PUSH_FRONT: push_front = 1'b1;
            CMD_POP_BACK:   pop_back   = 1'b1;
            CMD_POP_FRONT:  pop_front  = 1'b1;
            default:        ;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && (push_back || push_front) && !full)
            count_next = count_reg + CNT_W'(1);
        else if (accept && (pop_back || pop_front) && !empty)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        ctrl.shift_r = accept && push_front && !full;
        ctrl.shift_l = accept && pop_front && !empty;
        for (int i = 0; i < DEPTH; i++)
        begin
            // back write lands in the first free cell
            wr_sel[i] = accept && push_back && !full && (count_reg == CNT_W'(i));
            rd_sel[i] = !empty && ((pop_front && (i == 0)) ||
                                   (pop_back && (count_reg == CNT_W'(i + 1))));
        end
        status.is_empty = (count_next == '0);
        status.overflow = (push_back || push_front) && full;
        status.pop_hit  = (pop_back || pop_front) && !empty;
        status.pop_miss = (pop_back || pop_front) && empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    `ASSERT_CLK(a_count_range, count_reg <= CNT_W'(DEPTH), "fill count beyond depth")
    `ASSERT_CLK(a_idle_hold, !accept |=> $stable(count_reg), "count moved without a beat")
    `ASSERT_CLK(a_wr_onehot, $onehot0(wr_sel), "more than one cell written")
    `ASSERT_NEVER(a_ovf_grow, accept && status.overflow && (count_next != count_reg),
                  "dropped push changed the count")

endmodule

// ===== rtl/core/double_ended_queue_core.sv =====
// top level of the deque core: a row of deq_cell words under deq_ctrl,
// with a registered result stage; uses deq_pkg and the macros
//
//  group  dir  tdata              tuser
//  s_*    in   data_in[31:0]      cmd[2:0]
//  m_*    out  data_out[31:0]     is_empty[0], overflow[1]
//
// one command per cycle unless a stalled result holds s_tready low; the result
// is registered and shows in the cycle after its beat is taken
// the front word always sits in the first cell; front pushes and pops move
// the whole row by one cell, back pushes and pops touch one cell only
// rst_n clears the fill count and the result valid flag; cell contents are kept
// a stalled result blocks the input only while it still waits on m_tready
`include "assert_macros.svh"
module double_ended_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_in[31:0]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_out[31:0]
    output logic [1:0]  m_tuser    // is_empty, overflow
);
    import deq_pkg::*;

    logic          accept;
    cell_ctrl_t    ctrl;
    logic [DEPTH-1:0] wr_sel;
    logic [DEPTH-1:0] rd_sel;
    deq_status_t   status;
    word_t         cell_q [DEPTH];
    word_t         rd_word;
    word_t         data_out_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    word_t         out_data_reg;
    logic          out_empty_reg;
    logic          out_ovf_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    deq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (s_tuser),
        .ctrl   (ctrl),
        .wr_sel (wr_sel),
        .rd_sel (rd_sel),
        .status (status)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t left_data;
        word_t right_data;

        if (i == 0)
        begin : g_first
            assign left_data = word_t'(s_tdata);
        end
        else
        begin : g_mid_l
            assign left_data = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = cell_q[i];
        end
        else
        begin : g_mid_r
            assign right_data = cell_q[i+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .wr_en      (wr_sel[i]),
            .data_in    (word_t'(s_tdata)),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_q[i])
        );
    end

    // and-or pick of the selected cell
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
            rd_word = rd_word | (cell_q[i] & {WORD_W{rd_sel[i]}});
    end

    always_comb
    begin
        priority if (status.pop_miss)
            data_out_next = '1;
        else if (status.pop_hit)
            data_out_next = rd_word;
        else
            data_out_next = '0;
    end

    always_comb
    begin
        priority if (accept)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg  <= data_out_next;
            out_empty_reg <= status.is_empty;
            out_ovf_reg   <= status.overflow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_ovf_reg, out_empty_reg};

    `ASSERT_CLK(a_ovf_zero, m_tvalid && m_tuser[1] |-> m_tdata == '0, "dropped push with data")
    `ASSERT_CLK(a_ovf_full, m_tvalid && m_tuser[1] |-> !m_tuser[0], "overflow on empty queue")

endmodule

// ===== sim/double_ended_queue_core_test.sv =====
// self-checking testbench for double_ended_queue_core: a stimulus table, then random
// push/pop traffic with random stalls on both streams, checked against a ring-buffer predictor
// depends on deq_pkg and the core rtl only
`timescale 1ns / 100ps

module double_ended_queue_core_test;

    import deq_pkg::*;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1925;
    localparam int HOLD_OFF_AT = 400;
    localparam int DRAIN_PAUSE_AT = 1000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        word_t data;
        logic  is_empty;
        logic  overflow;
    } deq_result_t;

    typedef struct packed {
        logic [2:0]  cmd;
        word_t       data;
        logic        typed;
        deq_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // data_in[31:0]
    logic [2:0]  s_tuser = '0;      // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // data_out[31:0]
    logic [1:0]  m_tuser;           // is_empty, overflow

    // typed-in expectation that travels alongside the current input beat
    logic        beat_typed = 1'b0;
    deq_result_t beat_want = '0;

    stim_row_t   directed_rows[$];
    deq_result_t pending_results[$];

    // shadow ring state
    word_t shadow_ring [DEPTH];
    int    shadow_front = 0;
    int    shadow_count = 0;

    int  errors = 0;
    int  cycle_count = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  hold_off_req = 1'b0;

    double_ended_queue_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("double_ended_queue_core_test: done, errors");
            $finish;
        end
    end

    // one command against the shadow ring; returns the result it should give
    function automatic deq_result_t apply_command(input logic [2:0] cmd, input word_t val);
        deq_result_t res;
        res.data = '0;
        res.overflow = 1'b0;
        case (cmd)
            CMD_PUSH_BACK:
                if (shadow_count == DEPTH)
                    res.overflow = 1'b1;
                else
                begin
                    shadow_ring[(shadow_front + shadow_count) % DEPTH] = val;
                    shadow_count++;
                end
            CMD_PUSH_FRONT:
                if (shadow_count == DEPTH)
                    res.overflow = 1'b1;
                else
                begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_front] = val;
                    shadow_count++;
                end
            CMD_POP_BACK:
                if (shadow_count == 0)
                    res.data = word_t'(-1);
                else
                begin
                    res.data = shadow_ring[(shadow_front + shadow_count - 1) % DEPTH];
                    shadow_count--;
                end
            CMD_POP_FRONT:
                if (shadow_count == 0)
                    res.data = word_t'(-1);
                else
                begin
                    res.data = shadow_ring[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            default: ;  // query and unused codes leave the ring alone
        endcase
        res.is_empty = (shadow_count == 0);
        return res;
    endfunction

    // scoreboard: output beats first, then the input beat of the same edge
    always @(posedge clk)
    begin
        deq_result_t got;
        deq_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.data = m_tdata;
                got.is_empty = m_tuser[0];
                got.overflow = m_tuser[1];
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no command pending: data_out %0d", got.data);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.data !== want.data)
                    begin
                        $error("data_out: expected %0d, got %0d", want.data, got.data);
                        errors++;
                    end
                    if (got.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0b, got %0b", want.is_empty,
                               got.is_empty);
                        errors++;
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", want.overflow,
                               got.overflow);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = apply_command(s_tuser, s_tdata);
                if (beat_typed)
                    want = beat_want;
                pending_results.push_back(want);
            end
        end
    end

    // result side: random stalls per beat, one long hold-off on request
    initial
    begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_idle_on = !rx_idle_on;
            stall = rx_idle_on ? $urandom_range(0, 18) : 0;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    function automatic void add_row(input logic [2:0] cmd, input word_t data, input logic typed,
                                    input word_t want_data, input logic want_empty,
                                    input logic want_ovf);
        stim_row_t row;
        row.cmd = cmd;
        row.data = data;
        row.typed = typed;
        row.want.data = want_data;
        row.want.is_empty = want_empty;
        row.want.overflow = want_ovf;
        directed_rows.push_back(row);
    endfunction

    task automatic send_command(input logic [2:0] cmd, input word_t val, input logic typed,
                                input deq_result_t want);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_idle_on = !tx_idle_on;
        gap = tx_idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= val;
        beat_typed <= typed;
        beat_want <= want;
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(0, 11))
            0: return word_t'(32'h7fff_ffff);
            1: return word_t'(32'h8000_0000);
            2: return word_t'(-1);
            3: return '0;
            default: return word_t'($urandom);
        endcase
    endfunction

    initial
    begin
        int          i;
        int          mode;
        int          push_pct;
        logic [2:0]  cmd;
        logic        front_side;
        deq_result_t none;
        none = '0;

        // empty queue: pops answer -1, query and unused codes answer 0
        add_row(CMD_POP_BACK, word_t'(32'h1357_9bdf), 1'b1, word_t'(-1), 1'b1, 1'b0);
        add_row(CMD_POP_FRONT, word_t'(-1), 1'b1, word_t'(-1), 1'b1, 1'b0);
        add_row(CMD_QUERY, word_t'(32'hffff_0000), 1'b1, '0, 1'b1, 1'b0);
        add_row(CMD_UNUSED_LO, word_t'(32'h5a5a_a5a5), 1'b1, '0, 1'b1, 1'b0);
        add_row(CMD_UNUSED_HI, word_t'(32'h0000_ffff), 1'b1, '0, 1'b1, 1'b0);
        // extremes through both ends
        add_row(CMD_PUSH_BACK, word_t'(32'h7fff_ffff), 1'b1, '0, 1'b0, 1'b0);
        add_row(CMD_PUSH_FRONT, word_t'(32'h8000_0000), 1'b1, '0, 1'b0, 1'b0);
        add_row(CMD_POP_FRONT, '0, 1'b1, word_t'(32'h8000_0000), 1'b0, 1'b0);
        add_row(CMD_POP_BACK, '0, 1'b1, word_t'(32'h7fff_ffff), 1'b1, 1'b0);
        // fill from both ends, then push onto a full queue
        for (i = 0; i < DEPTH; i++)
        begin
            if (i % 2)
                add_row(CMD_PUSH_FRONT, word_t'(~(32'h1 << i)), 1'b0, '0, 1'b0, 1'b0);
            else
                add_row(CMD_PUSH_BACK, word_t'(32'h1 << i), 1'b0, '0, 1'b0, 1'b0);
        end
        add_row(CMD_PUSH_BACK, word_t'(32'h1234_5678), 1'b1, '0, 1'b0, 1'b1);
        add_row(CMD_PUSH_FRONT, word_t'(32'hedcb_a987), 1'b1, '0, 1'b0, 1'b1);

        while (!rst_n) @(posedge clk);

        foreach (directed_rows[k])
            send_command(directed_rows[k].cmd, directed_rows[k].data, directed_rows[k].typed,
                         directed_rows[k].want);

        mode = 0;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOLD_OFF_AT)
                hold_off_req = 1'b1;
            if (i == DRAIN_PAUSE_AT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            // runs of fill-heavy, drain-heavy and balanced traffic
            if (i % 48 == 0)
                mode = $urandom_range(0, 2);
            push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            if ($urandom_range(0, 99) < 6)
                cmd = 3'($urandom_range(CMD_QUERY, CMD_UNUSED_HI));
            else
            begin
                front_side = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < push_pct)
                    cmd = front_side ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                else
                    cmd = front_side ? CMD_POP_FRONT : CMD_POP_BACK;
            end
            send_command(cmd, pick_word(), 1'b0, none);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("double_ended_queue_core_test: done, clean");
        else
            $display("double_ended_queue_core_test: done, errors");
        $finish;
    end

endmodule
